// ----- hdl/tril_pkg.sv -----
// ----------------------------------------------------------------------------
// tril_pkg
// shared types and codes for the triangle lister
// ----------------------------------------------------------------------------
package tril_pkg;

    // input actions
    localparam logic [1:0] ACT_ADD   = 2'd0;
    localparam logic [1:0] ACT_DEL   = 2'd1;
    localparam logic [1:0] ACT_QUERY = 2'd2;
    localparam logic [1:0] ACT_LIST  = 2'd3;

    // row unit operations
    localparam logic [1:0] UNIT_SET = 2'd0;
    localparam logic [1:0] UNIT_CLR = 2'd1;
    localparam logic [1:0] UNIT_TRI = 2'd2;

    // listing result limit and counter width
    localparam int unsigned MAX_RESULTS = 30;
    localparam int unsigned CNT_W       = 5;

    // result item as passed from the sequencer to the output register
    typedef struct packed {
        logic        status;
        logic        edge_present;
        logic [4:0]  second_vertex;
        logic [31:0] third_mask;
        logic        last;
    } res_t;

endpackage

// ----- hdl/undirected_graph_triangle_lister_top.sv -----
// ----------------------------------------------------------------------------
// undirected_graph_triangle_lister_top
// adjacency-matrix graph with edge add, delete, query and triangle listing
// ----------------------------------------------------------------------------
// The graph lives in a VERTICES x VERTICES bit memory (one row per vertex,
// symmetric, empty after reset) with one write and one read port. The block
// takes one item at a time and holds in_stall high until the item's last
// result has left the sequencer. An edge add or delete reads and writes row a,
// then row b; a query reads row a and tests bit b. A triangle listing from
// start vertex s reads row s and then one row per cycle for every vertex
// above s, up to the result limit, unless the output side stalls it. The
// single read port of the row memory makes these reads one after another.
// Listing results come in increasing order of second vertex, each carrying
// the mask of third vertices; one result is held back in the sequencer so
// that the final one can carry last. A listing with no triangle gives one
// empty result, and an out-of-range vertex gives one result with status set
// and leaves the graph alone.
// ----------------------------------------------------------------------------
module undirected_graph_triangle_lister_top #(
    parameter int VERTICES = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    // input item channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  action,
    input  logic [7:0]  vertex_a,
    input  logic [7:0]  vertex_b,
    // result item channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic        status,
    output logic        edge_present,
    output logic [4:0]  second_vertex,
    output logic [31:0] third_mask,
    output logic        last
);

    localparam int VW = $clog2(VERTICES);

    // sequencer to output register
    logic            res_valid;
    logic            res_ready;
    tril_pkg::res_t  res;

    // row memory ports
    logic                wr_en;
    logic [VW-1:0]       wr_addr;
    logic [VERTICES-1:0] wr_data;
    logic                rd_en;
    logic [VW-1:0]       rd_addr;
    logic [VERTICES-1:0] rd_row;

    // output register
    logic            out_valid_reg;
    tril_pkg::res_t  out_reg;

    tril_row_mem #(
        .ROWS  (VERTICES),
        .ROW_W (VERTICES)
    ) u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_row)
    );

    tril_ctrl #(
        .VERTICES (VERTICES)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .action    (action),
        .vertex_a  (vertex_a),
        .vertex_b  (vertex_b),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_row    (rd_row)
    );

    // the output register takes a new item when empty or being drained
    assign res_ready = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = out_reg.status;
    assign edge_present  = out_reg.edge_present;
    assign second_vertex = out_reg.second_vertex;
    assign third_mask    = out_reg.third_mask;
    assign last          = out_reg.last;

endmodule

// ----- hdl/tril_row_mem.sv -----
// ----------------------------------------------------------------------------
// tril_row_mem
// adjacency row memory, one write and one registered read port,
// per-row valid bits so unwritten rows read as zero after reset
// ----------------------------------------------------------------------------
module tril_row_mem #(
    parameter int ROWS  = 32,
    parameter int ROW_W = 32
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     wr_en,
    input  logic [$clog2(ROWS)-1:0]  wr_addr,
    input  logic [ROW_W-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(ROWS)-1:0]  rd_addr,
    output logic [ROW_W-1:0]         rd_data
);

    logic [ROW_W-1:0] mem [ROWS];
    logic [ROWS-1:0]  valid_reg;
    logic [ROW_W-1:0] rd_data_reg;
    logic             rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

// ----- hdl/tril_row_unit.sv -----
// ----------------------------------------------------------------------------
// tril_row_unit
// shared row unit: set or clear one bit, or form the triangle mask
// ----------------------------------------------------------------------------
module tril_row_unit #(
    parameter int ROW_W = 32
) (
    input  logic [1:0]                mode,
    input  logic [ROW_W-1:0]          row,
    input  logic [ROW_W-1:0]          base,
    input  logic [$clog2(ROW_W)-1:0]  idx,
    output logic [ROW_W-1:0]          row_out,
    output logic                      bit_out
);

    logic [ROW_W-1:0] onehot;
    logic [ROW_W-1:0] above;

    assign onehot  = ROW_W'(1) << idx;
    assign above   = ({ROW_W{1'b1}} << idx) << 1;
    assign bit_out = row[idx];

    always_comb
    begin
        unique case (mode)
            tril_pkg::UNIT_SET: row_out = row | onehot;
            tril_pkg::UNIT_CLR: row_out = row & ~onehot;
            tril_pkg::UNIT_TRI: row_out = row & base & above;
            default:            row_out = row;
        endcase
    end

endmodule

// ----- hdl/tril_ctrl.sv -----
// ----------------------------------------------------------------------------
// tril_ctrl
// sequencer: runs edge updates, queries and the row-by-row triangle scan
// ----------------------------------------------------------------------------
module tril_ctrl #(
    parameter int VERTICES = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [1:0]                   action,
    input  logic [7:0]                   vertex_a,
    input  logic [7:0]                   vertex_b,
    output logic                         res_valid,
    input  logic                         res_ready,
    output tril_pkg::res_t               res,
    output logic                         wr_en,
    output logic [$clog2(VERTICES)-1:0]  wr_addr,
    output logic [VERTICES-1:0]          wr_data,
    output logic                         rd_en,
    output logic [$clog2(VERTICES)-1:0]  rd_addr,
    input  logic [VERTICES-1:0]          rd_row
);

    localparam int VW = $clog2(VERTICES);
    localparam int MW = (VERTICES > 32) ? 32 : VERTICES;
    localparam logic [VW:0]   V_END   = (VW+1)'(VERTICES);
    localparam logic [7:0]    V_LIMIT = 8'(VERTICES);
    localparam logic [tril_pkg::CNT_W-1:0] N_LAST = tril_pkg::CNT_W'(tril_pkg::MAX_RESULTS - 1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_WR_A = 3'd1;
    localparam logic [2:0] ST_WR_B = 3'd2;
    localparam logic [2:0] ST_QRY  = 3'd3;
    localparam logic [2:0] ST_BASE = 3'd4;
    localparam logic [2:0] ST_EVAL = 3'd5;
    localparam logic [2:0] ST_DONE = 3'd6;

    logic [2:0]                   state_reg, state_next;
    logic [1:0]                   act_reg, act_next;
    logic [VW-1:0]                a_reg, a_next;
    logic [VW-1:0]                b_reg, b_next;
    logic [VW-1:0]                s_reg, s_next;
    logic                         oor_reg, oor_next;
    logic                         pres_reg, pres_next;
    logic [VERTICES-1:0]          base_reg, base_next;
    logic                         pend_valid_reg, pend_valid_next;
    logic [VW-1:0]                pend_second_reg, pend_second_next;
    logic [VERTICES-1:0]          pend_mask_reg, pend_mask_next;
    logic [tril_pkg::CNT_W-1:0]   n_reg, n_next;

    logic [1:0]                   unit_mode;
    logic [VW-1:0]                unit_idx;
    logic [VERTICES-1:0]          unit_row;
    logic                         unit_bit;

    logic                         accept;
    logic                         oor;
    logic [VW:0]                  a_inc;
    logic [VW:0]                  s_inc;
    logic                         hit;
    logic                         go;

    tril_row_unit #(
        .ROW_W (VERTICES)
    ) u_unit (
        .mode    (unit_mode),
        .row     (rd_row),
        .base    (base_reg),
        .idx     (unit_idx),
        .row_out (unit_row),
        .bit_out (unit_bit)
    );

    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && !in_stall;
    assign oor      = (vertex_a >= V_LIMIT) ||
                      ((action != tril_pkg::ACT_LIST) && (vertex_b >= V_LIMIT));
    assign a_inc    = {1'b0, a_reg} + 1'b1;
    assign s_inc    = {1'b0, s_reg} + 1'b1;
    assign hit      = base_reg[s_reg] && (|unit_row);
    assign wr_data  = unit_row;

    always_comb
    begin
        state_next       = state_reg;
        act_next         = act_reg;
        a_next           = a_reg;
        b_next           = b_reg;
        s_next           = s_reg;
        oor_next         = oor_reg;
        pres_next        = pres_reg;
        base_next        = base_reg;
        pend_valid_next  = pend_valid_reg;
        pend_second_next = pend_second_reg;
        pend_mask_next   = pend_mask_reg;
        n_next           = n_reg;
        unit_mode        = tril_pkg::UNIT_TRI;
        unit_idx         = s_reg;
        rd_en            = 1'b0;
        rd_addr          = s_reg;
        wr_en            = 1'b0;
        wr_addr          = a_reg;
        go               = 1'b0;
        res_valid        = 1'b0;
        res              = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    act_next        = action;
                    a_next          = VW'(vertex_a);
                    b_next          = VW'(vertex_b);
                    oor_next        = oor;
                    pres_next       = 1'b0;
                    pend_valid_next = 1'b0;
                    n_next          = '0;
                    if (oor)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        rd_en   = 1'b1;
                        rd_addr = VW'(vertex_a);
                        unique case (action)
                            tril_pkg::ACT_ADD:   state_next = ST_WR_A;
                            tril_pkg::ACT_DEL:   state_next = ST_WR_A;
                            tril_pkg::ACT_QUERY: state_next = ST_QRY;
                            tril_pkg::ACT_LIST:  state_next = ST_BASE;
                        endcase
                    end
                end
            end
            ST_WR_A:
            begin
                // row a updated; row b read now (old data is fine for a self loop)
                unit_mode  = (act_reg == tril_pkg::ACT_DEL) ? tril_pkg::UNIT_CLR
                                                            : tril_pkg::UNIT_SET;
                unit_idx   = b_reg;
                wr_en      = 1'b1;
                wr_addr    = a_reg;
                rd_en      = 1'b1;
                rd_addr    = b_reg;
                state_next = ST_WR_B;
            end
            ST_WR_B:
            begin
                unit_mode  = (act_reg == tril_pkg::ACT_DEL) ? tril_pkg::UNIT_CLR
                                                            : tril_pkg::UNIT_SET;
                unit_idx   = a_reg;
                wr_en      = 1'b1;
                wr_addr    = b_reg;
                state_next = ST_DONE;
            end
            ST_QRY:
            begin
                unit_idx   = b_reg;
                pres_next  = unit_bit;
                state_next = ST_DONE;
            end
            ST_BASE:
            begin
                base_next = rd_row;
                if (a_inc == V_END)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    s_next     = a_inc[VW-1:0];
                    rd_en      = 1'b1;
                    rd_addr    = a_inc[VW-1:0];
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                // a new hit pushes out the held one, which is then known not last
                go = 1'b1;
                if (hit && pend_valid_reg)
                begin
                    res_valid         = 1'b1;
                    res.second_vertex = 5'(pend_second_reg);
                    res.third_mask    = 32'(pend_mask_reg[MW-1:0]);
                    go                = res_ready;
                end
                if (go)
                begin
                    if (hit)
                    begin
                        pend_valid_next  = 1'b1;
                        pend_second_next = s_reg;
                        pend_mask_next   = unit_row;
                        n_next           = n_reg + 1'b1;
                    end
                    if ((s_inc == V_END) || (hit && (n_reg == N_LAST)))
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        s_next  = s_inc[VW-1:0];
                        rd_en   = 1'b1;
                        rd_addr = s_inc[VW-1:0];
                    end
                end
            end
            ST_DONE:
            begin
                res_valid        = 1'b1;
                res.status       = oor_reg;
                res.edge_present = pres_reg;
                res.last         = 1'b1;
                if (pend_valid_reg)
                begin
                    res.second_vertex = 5'(pend_second_reg);
                    res.third_mask    = 32'(pend_mask_reg[MW-1:0]);
                end
                if (res_ready)
                begin
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            pend_valid_reg <= 1'b0;
            n_reg          <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            pend_valid_reg <= pend_valid_next;
            n_reg          <= n_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg         <= act_next;
        a_reg           <= a_next;
        b_reg           <= b_next;
        s_reg           <= s_next;
        oor_reg         <= oor_next;
        pres_reg        <= pres_next;
        base_reg        <= base_next;
        pend_second_reg <= pend_second_next;
        pend_mask_reg   <= pend_mask_next;
    end

    // out-of-range results are single and final
    a_oor_last: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.status) |-> res.last)
        else $error("out-of-range result without last");

    // an accepted item holds off the next one
    a_accept_stall: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> in_stall)
        else $error("no stall after accept");

    // the result count never passes the limit
    a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
        n_reg <= tril_pkg::CNT_W'(tril_pkg::MAX_RESULTS))
        else $error("listing result count overflow");

    // nothing is held over between items
    a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !pend_valid_reg)
        else $error("pending result left in idle");

endmodule

// ----- tb/undirected_graph_triangle_lister_checker.sv -----
// ----------------------------------------------------------------------------
// undirected_graph_triangle_lister_checker
// watches both channels, keeps its own copy of the graph and compares results
// ----------------------------------------------------------------------------
module undirected_graph_triangle_lister_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [1:0]  action,
    input  logic [7:0]  vertex_a,
    input  logic [7:0]  vertex_b,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic        status,
    input  logic        edge_present,
    input  logic [4:0]  second_vertex,
    input  logic [31:0] third_mask,
    input  logic        last,
    output int          mismatches,
    output int          results_waiting
);

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NV = 32;

    logic [31:0]    graph_rows [NV];
    tril_pkg::res_t awaited_results [$];

    initial begin
        mismatches      = 0;
        results_waiting = 0;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatches < 100)
            $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
        mismatches++;
    endtask

    // append one expected result at the tail of the queue
    task automatic queue_result(input tril_pkg::res_t item);
        awaited_results.insert(awaited_results.size(), item);
    endtask

    // apply one accepted item to the graph copy and queue its results
    task automatic predict_action(input logic [1:0] act, input logic [7:0] va,
                                  input logic [7:0] vb);
        tril_pkg::res_t r;
        tril_pkg::res_t batch [$];
        logic [31:0]    third;
        int             s;
        int             v;
        r      = '0;
        r.last = 1'b1;
        s      = int'(va);
        if (va >= NV || (act != tril_pkg::ACT_LIST && vb >= NV)) begin
            r.status = 1'b1;
            queue_result(r);
        end else if (act == tril_pkg::ACT_ADD) begin
            graph_rows[va][vb] = 1'b1;
            graph_rows[vb][va] = 1'b1;
            queue_result(r);
        end else if (act == tril_pkg::ACT_DEL) begin
            graph_rows[va][vb] = 1'b0;
            graph_rows[vb][va] = 1'b0;
            queue_result(r);
        end else if (act == tril_pkg::ACT_QUERY) begin
            r.edge_present = graph_rows[va][vb];
            queue_result(r);
        end else begin
            for (v = s + 1; v < NV && batch.size() < tril_pkg::MAX_RESULTS; v++) begin
                if (graph_rows[s][v]) begin
                    third = graph_rows[v] & graph_rows[s] & (32'hFFFF_FFFF << (v + 1));
                    if (third != '0) begin
                        r               = '0;
                        r.second_vertex = v[4:0];
                        r.third_mask    = third;
                        batch.insert(batch.size(), r);
                    end
                end
            end
            if (batch.size() == 0) begin
                r      = '0;
                r.last = 1'b1;
                batch.insert(batch.size(), r);
            end else begin
                batch[batch.size() - 1].last = 1'b1;
            end
            foreach (batch[i])
                queue_result(batch[i]);
        end
    endtask

    task automatic check_result();
        tril_pkg::res_t want;
        if (awaited_results.size() == 0) begin
            report_mismatch("unexpected item", {31'b0, last}, '0);
        end else begin
            want = awaited_results.pop_front();
            if (status !== want.status)
                report_mismatch("status", {31'b0, status}, {31'b0, want.status});
            if (edge_present !== want.edge_present)
                report_mismatch("edge_present", {31'b0, edge_present},
                                {31'b0, want.edge_present});
            if (second_vertex !== want.second_vertex)
                report_mismatch("second_vertex", {27'b0, second_vertex},
                                {27'b0, want.second_vertex});
            if (third_mask !== want.third_mask)
                report_mismatch("third_mask", third_mask, want.third_mask);
            if (last !== want.last)
                report_mismatch("last", {31'b0, last}, {31'b0, want.last});
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            foreach (graph_rows[i])
                graph_rows[i] = '0;
            awaited_results.delete();
        end else begin
            if (in_valid && !in_stall)
                predict_action(action, vertex_a, vertex_b);
            if (out_valid && !out_stall)
                check_result();
        end
        results_waiting = awaited_results.size();
    end

endmodule

// ----- tb/undirected_graph_triangle_lister_top_test.sv -----
// ----------------------------------------------------------------------------
// undirected_graph_triangle_lister_top_test
// drives edge adds, deletes, queries and triangle listings with bursty input
// and a stalling receiver; the checker beside the block predicts and compares
// ----------------------------------------------------------------------------
module undirected_graph_triangle_lister_top_test;

    timeunit 1ns;
    timeprecision 1ps;

    // clock and reset, reset held low from time zero
    logic        clk = 1'b0;
    logic        rst_n = 1'b0;

    // input item channel, all known from the start
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  action = tril_pkg::ACT_ADD;
    logic [7:0]  vertex_a = '0;
    logic [7:0]  vertex_b = '0;

    // result item channel
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        status;
    logic        edge_present;
    logic [4:0]  second_vertex;
    logic [31:0] third_mask;
    logic        last;

    int          mismatches;
    int          results_waiting;

    // sender burst bookkeeping
    int          burst_left = 0;

    // long receiver hold-off, asked for by the stimulus, served by the receiver
    bit          hold_request = 1'b0;
    bit          hold_served = 1'b0;

    always #4 clk = ~clk;

    undirected_graph_triangle_lister_top DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .action        (action),
        .vertex_a      (vertex_a),
        .vertex_b      (vertex_b),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .edge_present  (edge_present),
        .second_vertex (second_vertex),
        .third_mask    (third_mask),
        .last          (last)
    );

    undirected_graph_triangle_lister_checker checker_i (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .action          (action),
        .vertex_a        (vertex_a),
        .vertex_b        (vertex_b),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .status          (status),
        .edge_present    (edge_present),
        .second_vertex   (second_vertex),
        .third_mask      (third_mask),
        .last            (last),
        .mismatches      (mismatches),
        .results_waiting (results_waiting)
    );

    // offer one item and hold it until accepted; called just after a rising edge
    // stall is sampled at the falling edge, when everything driven at the
    // rising edge has settled, so acceptance never depends on event order
    task automatic send_item(input logic [1:0] act, input logic [7:0] va,
                             input logic [7:0] vb);
        bit took;
        int gap;
        took = 1'b0;
        in_valid <= 1'b1;
        action   <= act;
        vertex_a <= va;
        vertex_b <= vb;
        while (!took) begin
            @(negedge clk);
            took = !in_stall;
            @(posedge clk);
        end
        // end of burst: maybe drop valid for a while, never in the same step
        // that raises it again
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end else begin
            burst_left--;
        end
    endtask

    // vertex mix: a small cluster so that triangles form, equally often a spread
    // over the whole graph, and a few out of range to hit the status path
    function automatic logic [7:0] pick_vertex();
        int r;
        r = $urandom_range(0, 19);
        if (r < 2)
            return 8'($urandom_range(32, 255));
        else if (r < 11)
            return 8'($urandom_range(0, 7));
        else
            return 8'($urandom_range(0, 31));
    endfunction

    // receiver: phases of different stall patterns, plus one long hold-off
    // counted here so the block fills up and pushes back on its input
    initial begin : receiver
        int mode;
        int phase_len;
        int k;
        forever begin
            if (hold_request && !hold_served) begin
                out_stall <= 1'b1;
                repeat (400) @(posedge clk);
                hold_served = 1'b1;
            end
            mode      = $urandom_range(0, 3);
            phase_len = $urandom_range(5, 60);
            for (k = 0; k < phase_len; k++) begin
                unique case (mode)
                    0: out_stall <= 1'b0;
                    1: out_stall <= 1'($urandom_range(0, 1));
                    2: out_stall <= ($urandom_range(0, 3) != 0);
                    default: out_stall <= (k % 4 == 0);
                endcase
                @(posedge clk);
            end
        end
    end

    initial begin : stimulus
        int          n;
        int          r;
        logic [1:0]  act;
        logic [7:0]  va;
        logic [7:0]  vb;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part
        send_item(tril_pkg::ACT_LIST, 8'd0, 8'd0);       // listing on the empty graph
        send_item(tril_pkg::ACT_QUERY, 8'd0, 8'd0);
        send_item(tril_pkg::ACT_ADD, 8'd0, 8'd1);        // one triangle 0-1-2
        send_item(tril_pkg::ACT_ADD, 8'd1, 8'd2);
        send_item(tril_pkg::ACT_ADD, 8'd0, 8'd2);
        send_item(tril_pkg::ACT_QUERY, 8'd2, 8'd0);      // symmetric bit
        send_item(tril_pkg::ACT_LIST, 8'd0, 8'd255);     // vertex_b ignored for a listing
        send_item(tril_pkg::ACT_ADD, 8'd0, 8'd0);        // self loop
        send_item(tril_pkg::ACT_QUERY, 8'd0, 8'd0);
        send_item(tril_pkg::ACT_LIST, 8'd0, 8'd0);       // self loop is not a triangle
        send_item(tril_pkg::ACT_DEL, 8'd0, 8'd0);
        send_item(tril_pkg::ACT_ADD, 8'd31, 8'd30);      // triangle at the top vertices
        send_item(tril_pkg::ACT_ADD, 8'd31, 8'd29);
        send_item(tril_pkg::ACT_ADD, 8'd29, 8'd30);
        send_item(tril_pkg::ACT_LIST, 8'd29, 8'd0);
        send_item(tril_pkg::ACT_LIST, 8'd31, 8'd31);     // highest start, nothing above
        send_item(tril_pkg::ACT_DEL, 8'd5, 8'd6);        // deleting a missing edge
        send_item(tril_pkg::ACT_ADD, 8'd255, 8'd0);      // out of range, each action
        send_item(tril_pkg::ACT_ADD, 8'd0, 8'd32);
        send_item(tril_pkg::ACT_QUERY, 8'd31, 8'd255);
        send_item(tril_pkg::ACT_DEL, 8'd128, 8'd3);
        send_item(tril_pkg::ACT_LIST, 8'd32, 8'd0);
        send_item(tril_pkg::ACT_LIST, 8'd255, 8'd170);
        send_item(tril_pkg::ACT_DEL, 8'd0, 8'd1);        // break the low triangle
        send_item(tril_pkg::ACT_LIST, 8'd0, 8'd85);

        // random part, with the long receiver hold-off early on
        hold_request = 1'b1;
        for (n = 0; n < 145; n++) begin
            r = $urandom_range(0, 9);
            if (r < 4)
                act = tril_pkg::ACT_ADD;
            else if (r == 4)
                act = tril_pkg::ACT_DEL;
            else if (r < 7)
                act = tril_pkg::ACT_QUERY;
            else
                act = tril_pkg::ACT_LIST;
            va = pick_vertex();
            vb = (act == tril_pkg::ACT_LIST) ? 8'($urandom_range(0, 255)) : pick_vertex();
            send_item(act, va, vb);
        end
        in_valid <= 1'b0;

        // drain: wait for every expected item, then keep the clock running
        // so that any stray extra result is seen by the checker
        @(negedge clk);
        wait (results_waiting == 0);
        repeat (64) @(posedge clk);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // watchdog, far above the slowest legal run
    initial begin : watchdog
        #4ms;
        $display("tb: failure");
        $finish;
    end

endmodule

// ----- undirected_graph_triangle_lister_top.f -----
hdl/tril_pkg.sv
hdl/tril_row_mem.sv
hdl/tril_row_unit.sv
hdl/tril_ctrl.sv
hdl/undirected_graph_triangle_lister_top.sv
tb/undirected_graph_triangle_lister_checker.sv
tb/undirected_graph_triangle_lister_top_test.sv
